FILE: src/reflectance_line_position_unit_assert.svh
// Assertion helpers for the reflectance line-position unit.
// Both macros sample on the rising edge of clk and are quiet during reset.
`ifndef REFLECTANCE_LINE_POSITION_UNIT_ASSERT_SVH
`define REFLECTANCE_LINE_POSITION_UNIT_ASSERT_SVH

`define RLP_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("line-position unit: same-cycle check failed");

`define RLP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("line-position unit: next-cycle check failed");

`endif

FILE: src/rlp_pkg.sv
package rlp_pkg;

    localparam int unsigned SENSOR_SLOTS_DEF = 8;

    localparam int unsigned RAW_W   = 12;
    localparam int unsigned CAL_W   = 10;
    localparam int unsigned SN_W    = 3;
    localparam int unsigned POS_W   = 14;
    localparam int unsigned SUM_W   = 13;
    localparam int unsigned WSUM_W  = 26;
    localparam int unsigned WGT_W   = 13;
    localparam int unsigned PROD_W  = CAL_W + WGT_W;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned NEFF_W  = 5;

    localparam int unsigned RAW_MAX        = 4095;
    localparam int unsigned SCALE_MAX      = 1000;
    localparam int unsigned MIN_PER_SENSOR = 50;
    localparam int unsigned SUM_MAX        = 8191;
    localparam int unsigned WSUM_MAX       = 67108863;

    localparam int unsigned DIVD_W    = WSUM_W;
    localparam int unsigned DIVS_W    = SUM_W;
    localparam int unsigned DIV_STEPS = DIVD_W;
    localparam int unsigned DSTEP_W   = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_CALIBRATE = 2'd0;
    localparam logic [1:0] OP_MEASURE   = 2'd1;
    localparam logic [1:0] OP_CLEAR     = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_SUBTRACT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LINE       = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [WGT_W-1:0] sensor_weight(input logic [SN_W-1:0] sn);
        return WGT_W'(sn) * WGT_W'(SCALE_MAX);
    endfunction

endpackage

FILE: src/rlp_div.sv
module rlp_div (
    input  logic             clk,
    input  logic             rst_n,
    input  rlp_pkg::div_req_t req,
    output rlp_pkg::div_rsp_t rsp
);
    import rlp_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DSTEP_W-1:0]  cnt_reg;
    logic [DIVS_W-1:0]   dvs_reg;
    logic [DIVS_W-1:0]   rem_reg;
    logic [DIVD_W-1:0]   quo_reg;

    logic [DIVS_W:0]     trial;
    logic                fits;
    logic [DIVS_W-1:0]   rem_next;
    logic [DIVD_W-1:0]   quo_next;

    // One restoring step: the next dividend bit joins the partial remainder.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : DIVS_W'(trial);
        quo_next = {quo_reg[DIVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DSTEP_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: src/reflectance_line_position_unit.sv
// Calibrate, clear and out-of-range beats pass from acceptance through S_EXEC to S_DONE.
// A measure beat scales in the 26-step divider (S_SDIV) unless uncalibrated or at floor.
// A frame's last sensor adds S_POS, and S_PDIV when the same divider forms the position.
// One beat is in work at a time; the next is taken while a finished result waits.
// Reset (rst_n, asynchronous, active low) sets 8 sensors, both modes off, all minimum marks
// to 4095, all maximum marks and both frame accumulators to zero.
module reflectance_line_position_unit #(
    parameter int unsigned SENSOR_SLOTS = rlp_pkg::SENSOR_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [rlp_pkg::SN_W-1:0]            sensor_number,
    input  logic [rlp_pkg::RAW_W-1:0]           lit_reading,
    input  logic [rlp_pkg::RAW_W-1:0]           ambient_reading,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rlp_pkg::CAL_W-1:0]           calibrated_value,
    output logic [rlp_pkg::SN_W-1:0]            echo_sensor,
    output logic                                position_valid,
    output logic signed [rlp_pkg::POS_W-1:0]    line_position,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rlp_pkg::*;

    localparam int unsigned IDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
    localparam logic [NEFF_W-1:0] SLOTS_N = NEFF_W'(SENSOR_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SDIV,
        S_MUL,
        S_ACCUM,
        S_POS,
        S_PDIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                amb_sub_reg;
    logic                white_reg;
    logic [RAW_W-1:0]    low_reg  [SENSOR_SLOTS];
    logic [RAW_W-1:0]    high_reg [SENSOR_SLOTS];
    logic [SUM_W-1:0]    sum_reg;
    logic [WSUM_W-1:0]   wsum_reg;

    logic [1:0]          op_reg;
    logic [SN_W-1:0]     sn_reg;
    logic [RAW_W-1:0]    lit_reg;
    logic [RAW_W-1:0]    amb_reg;
    logic [CAL_W-1:0]    cal_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                posv_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CAL_W-1:0]    out_cal_reg;
    logic [SN_W-1:0]     out_sn_reg;
    logic                out_posv_reg;
    logic [POS_W-1:0]    out_pos_reg;

    logic [NEFF_W-1:0]   n_eff;
    logic [IDX_W-1:0]    idx;
    logic                skip;
    logic                is_last;
    logic [RAW_W-1:0]    raw;
    logic [RAW_W-1:0]    mn;
    logic [RAW_W-1:0]    mx;
    logic                empty_cal;
    logic                at_floor;
    logic [21:0]         numer;
    logic [RAW_W-1:0]    span;
    logic [CAL_W-1:0]    scaled;
    logic [CAL_W-1:0]    scaled_out;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_next;
    logic [WSUM_W:0]     wsum_add;
    logic [WSUM_W-1:0]   wsum_next;
    logic [SUM_W-1:0]    min_sum;
    logic                low_sum;
    logic [POS_W-1:0]    pos_max;
    logic [POS_W-1:0]    pos_clamped;
    logic                out_load;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    rlp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        n_eff     = ({1'b0, count_reg} < SLOTS_N) ? {1'b0, count_reg} : SLOTS_N;
        idx       = IDX_W'(sn_reg);
        skip      = (NEFF_W'(sn_reg) >= n_eff) || (op_reg != OP_CALIBRATE
                    && op_reg != OP_MEASURE && op_reg != OP_CLEAR);
        is_last   = NEFF_W'(sn_reg) == (n_eff - 1'b1);
        if (amb_sub_reg)
        begin
            raw = (lit_reg > amb_reg) ? (lit_reg - amb_reg) : '0;
        end
        else
        begin
            raw = lit_reg;
        end
        mn        = low_reg[idx];
        mx        = high_reg[idx];
        empty_cal = mx <= mn;
        at_floor  = raw <= mn;
        numer     = 22'(raw - mn) * 22'(SCALE_MAX);
        span      = mx - mn;

        scaled     = (div_rsp.quotient > DIVD_W'(SCALE_MAX)) ? CAL_W'(SCALE_MAX)
                     : CAL_W'(div_rsp.quotient);
        scaled_out = white_reg ? CAL_W'(CAL_W'(SCALE_MAX) - scaled) : scaled;

        sum_add   = (sn_reg == '0) ? (SUM_W + 1)'(cal_reg)
                    : ({1'b0, sum_reg} + (SUM_W + 1)'(cal_reg));
        sum_next  = (sum_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : SUM_W'(sum_add);
        wsum_add  = (sn_reg == '0) ? (WSUM_W + 1)'(prod_reg)
                    : ({1'b0, wsum_reg} + (WSUM_W + 1)'(prod_reg));
        wsum_next = (wsum_add > (WSUM_W + 1)'(WSUM_MAX)) ? WSUM_W'(WSUM_MAX)
                    : WSUM_W'(wsum_add);

        min_sum     = SUM_W'(n_eff) * SUM_W'(MIN_PER_SENSOR);
        low_sum     = sum_reg < min_sum;
        pos_max     = POS_W'(n_eff - 1'b1) * POS_W'(SCALE_MAX);
        pos_clamped = (div_rsp.quotient > DIVD_W'(pos_max)) ? pos_max
                      : POS_W'(div_rsp.quotient);

        div_req.start    = ((state_reg == S_EXEC) && !skip && (op_reg == OP_MEASURE)
                           && !empty_cal && !at_floor)
                           || ((state_reg == S_POS) && !low_sum);
        div_req.dividend = (state_reg == S_POS) ? wsum_reg : DIVD_W'(numer);
        div_req.divisor  = (state_reg == S_POS) ? sum_reg : DIVS_W'(span);

        out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= CNT_W'(8);
            amb_sub_reg   <= 1'b0;
            white_reg     <= 1'b0;
            sum_reg       <= '0;
            wsum_reg      <= '0;
            for (int i = 0; i < SENSOR_SLOTS; i++)
            begin
                low_reg[i]  <= RAW_W'(RAW_MAX);
                high_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SENSOR_COUNT:     count_reg   <= cfg_data;
                    CFG_AMBIENT_SUBTRACT: amb_sub_reg <= cfg_data[0];
                    CFG_WHITE_LINE:       white_reg   <= cfg_data[0];
                    default:              ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (skip)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (op_reg == OP_CALIBRATE)
                    begin
                        if (raw < mn)
                        begin
                            low_reg[idx] <= raw;
                        end
                        if (raw > mx)
                        begin
                            high_reg[idx] <= raw;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (op_reg == OP_CLEAR)
                    begin
                        low_reg[idx]  <= RAW_W'(RAW_MAX);
                        high_reg[idx] <= '0;
                        state_reg     <= S_DONE;
                    end
                    else if (empty_cal || at_floor)
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_SDIV;
                    end
                end
                S_SDIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACCUM;
                end
                S_ACCUM:
                begin
                    sum_reg   <= sum_next;
                    wsum_reg  <= wsum_next;
                    state_reg <= is_last ? S_POS : S_DONE;
                end
                S_POS:
                begin
                    sum_reg   <= '0;
                    wsum_reg  <= '0;
                    state_reg <= low_sum ? S_DONE : S_PDIV;
                end
                S_PDIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode;
            sn_reg  <= sensor_number;
            lit_reg <= lit_reading;
            amb_reg <= ambient_reading;
        end
        case (state_reg)
            S_EXEC:
            begin
                posv_reg <= 1'b0;
                pos_reg  <= '0;
                if (!skip && (op_reg == OP_MEASURE) && !empty_cal && white_reg)
                begin
                    cal_reg <= CAL_W'(SCALE_MAX);
                end
                else
                begin
                    cal_reg <= '0;
                end
            end
            S_SDIV:
            begin
                if (div_rsp.done)
                begin
                    cal_reg <= scaled_out;
                end
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(cal_reg) * PROD_W'(sensor_weight(sn_reg));
            end
            S_POS:
            begin
                posv_reg <= 1'b1;
                pos_reg  <= '1;
            end
            S_PDIV:
            begin
                if (div_rsp.done)
                begin
                    pos_reg <= pos_clamped;
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_cal_reg  <= cal_reg;
            out_sn_reg   <= sn_reg;
            out_posv_reg <= posv_reg;
            out_pos_reg  <= pos_reg;
        end
    end

    assign in_ready         = state_reg == S_IDLE;
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign calibrated_value = out_cal_reg;
    assign echo_sensor      = out_sn_reg;
    assign position_valid   = out_posv_reg;
    assign line_position    = out_pos_reg;

    `include "reflectance_line_position_unit_assert.svh"

    `RLP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `RLP_ASSERT_SAME(a_cal_in_range, out_valid, calibrated_value <= 10'd1000)
    `RLP_ASSERT_SAME(a_no_position_is_zero, out_valid && !position_valid, line_position == '0)
    `RLP_ASSERT_SAME(a_position_in_range, out_valid && position_valid,
        line_position == -14'sd1 || (line_position >= 14'sd0 && line_position <= 14'sd7000))

endmodule
